[rtl/trapezoid_motion_profiler_defines.svh]
`ifndef TRAPEZOID_MOTION_PROFILER_DEFINES_SVH
`define TRAPEZOID_MOTION_PROFILER_DEFINES_SVH

// Plain check, sampled on the rising edge, quiet while in reset.
`define TMP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A signal holds for the next cycle whenever cond is seen.
`define TMP_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

[rtl/tmp_pkg.sv]
`timescale 1ns / 1ps
package tmp_pkg;

  localparam int SPEED_BITS    = 24;
  localparam int POSITION_BITS = 32;
  localparam int TICK_W        = 24;
  localparam int DLY_W         = 16;
  localparam int KIND_W        = 3;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = SPEED_BITS;
  // plan distance in Q.9 plus sign
  localparam int STEPS_W       = POSITION_BITS + 10;
  localparam int V_W           = SPEED_BITS + 1;
  localparam int OFF_W         = SPEED_BITS + 2;
  localparam int DVS_W         = SPEED_BITS + 2;
  localparam int PROD_W        = TICK_W + V_W;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_START, KIND_TICK, KIND_PULSE, KIND_STOP, KIND_DISABLE
  } kind_e;

  typedef enum logic [1:0] {ST_ACCEPTED, ST_BUSY, ST_INVALID} status_e;
  typedef enum logic [1:0] {MOTOR_STOPPED, MOTOR_STARTING, MOTOR_MOVING} motor_e;
  typedef enum logic [1:0] {DRV_OFF, DRV_ENABLING, DRV_ON} drv_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_SPEED, CFG_STOP_SPEED, CFG_ACCEL_STEP, CFG_DECEL_STEP,
    CFG_ENABLE_DELAY, CFG_DISABLE_DELAY
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_PLAN, S_CDIV, S_MUL, S_APPLY, S_FDIV, S_RESULT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_EXEC, CMD_STEP, CMD_CDIV_GO, CMD_CDIV_TAKE, CMD_MUL,
    CMD_APPLY, CMD_FDIV_GO, CMD_FDIV_TAKE, CMD_FINAL, CMD_OUT
  } cmd_e;

  typedef struct packed {
    logic is_start;
    logic start_ok;
    logic loop_go;
    logic need_div;
    logic direct_end;
    logic div_done;
  } dp_status_t;

endpackage

[rtl/tmp_div.sv]
`timescale 1ns / 1ps
module tmp_div import tmp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [STEPS_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]   divisor_i,
  output logic [STEPS_W-1:0] quotient_o,
  output logic               done_o
);

  localparam int CNT_W = $clog2(STEPS_W);

  logic [DVS_W:0]     rem_q, trial;
  logic [STEPS_W-1:0] quo_q;
  logic [DVS_W-1:0]   dvs_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q, fits;

  // restoring, one quotient bit a cycle
  assign trial = {rem_q[DVS_W-1:0], quo_q[STEPS_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STEPS_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
      quo_q <= {quo_q[STEPS_W-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

[rtl/tmp_datapath.sv]
`timescale 1ns / 1ps
module tmp_datapath import tmp_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cmd_e                            cmd_i,
  output dp_status_t                      status_o,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_W-1:0]            cfg_addr_i,
  input  logic [CFG_W-1:0]                cfg_wdata_i,
  input  logic [KIND_W-1:0]               kind_i,
  input  logic signed [POSITION_BITS-1:0] target_position_i,
  input  logic [SPEED_BITS-1:0]           speed_request_i,
  input  logic [TICK_W-1:0]               move_limit_i,
  output logic [1:0]                      status_code_o,
  output logic                            driver_on_o,
  output logic                            move_on_o,
  output logic [SPEED_BITS-1:0]           speed_out_o,
  output logic                            speed_changed_o,
  output logic signed [POSITION_BITS-1:0] position_now_o,
  output logic [1:0]                      motor_phase_o,
  output logic [1:0]                      driver_phase_o
);

  // configuration
  logic [SPEED_BITS-1:0] start_speed_q, stop_speed_q, accel_q, decel_q;
  logic [DLY_W-1:0]      en_dly_q, dis_dly_q;

  // latched item
  logic [KIND_W-1:0]        kind_q;
  logic [POSITION_BITS-1:0] tgt_q;
  logic [SPEED_BITS-1:0]    req_q;
  logic [TICK_W-1:0]        lim_q;

  // move state
  drv_e                     drv_q, drv_d;
  motor_e                   motor_q, motor_d;
  logic [SPEED_BITS-1:0]    speed_q, speed_d, goal_q, goal_d;
  logic [TICK_W-1:0]        te_q, te_d, tl_q, tl_d, dst_q, dst_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d, pgoal_q, pgoal_d;
  logic                     back_q, back_d;
  logic [DLY_W-1:0]         en_cnt_q, en_cnt_d, dis_cnt_q, dis_cnt_d;
  status_e                  stat_q, stat_d;
  logic                     chg_q, chg_d;

  // planner
  logic signed [STEPS_W-1:0] steps_q, steps_d;
  logic [V_W-1:0]            v_q, v_d;
  logic [OFF_W-1:0]          off_q, off_d;
  logic [TICK_W-1:0]         tm_q, tm_d, na_q, na_d, nd_q, nd_d, n_q, n_d;
  logic [PROD_W-1:0]         prod_q;

  // result register
  status_e                  o_stat_q;
  logic                     o_drv_on_q, o_move_on_q, o_chg_q;
  logic [SPEED_BITS-1:0]    o_speed_q;
  logic [POSITION_BITS-1:0] o_pos_q;
  motor_e                   o_motor_q;
  drv_e                     o_drv_q;

  logic                     busy_w, invalid_w, back_w;
  logic [POSITION_BITS-1:0] dist_w;
  logic signed [OFF_W:0]    d_w;
  logic                     dec_w, loop_go_w, grow_zero_w;
  logic [V_W-1:0]           sub_w;
  logic [SPEED_BITS-1:0]    grow_w, diff_w;
  logic [V_W-1:0]           up_w;
  logic [TICK_W:0]          r_w;
  logic                     div_go, div_done;
  logic [STEPS_W-1:0]       dividend_w, quo_w;
  logic [DVS_W-1:0]         divisor_w;

  assign busy_w    = motor_q != MOTOR_STOPPED;
  assign invalid_w = (lim_q == '0) || (req_q == '0) || (tgt_q == pos_q);
  assign back_w    = $signed(tgt_q) < $signed(pos_q);
  assign dist_w    = back_w ? pos_q - tgt_q : tgt_q - pos_q;

  // one plan step: ramp-down leg while v - off is above the floor
  assign d_w         = $signed({2'b00, v_q}) - $signed({1'b0, off_q});
  assign dec_w       = d_w > $signed({3'b000, stop_speed_q});
  assign sub_w       = dec_w ? d_w[V_W-1:0] : v_q;
  assign grow_w      = dec_w ? decel_q : accel_q;
  assign grow_zero_w = grow_w == '0;
  assign loop_go_w   = (v_q < {1'b0, goal_q}) && !steps_q[STEPS_W-1]
                       && (steps_q != '0) && (tm_q != '0);

  assign status_o.is_start   = kind_e'(kind_q) == KIND_START;
  assign status_o.start_ok   = !busy_w && !invalid_w;
  assign status_o.loop_go    = loop_go_w;
  assign status_o.need_div   = grow_zero_w && (sub_w != '0);
  assign status_o.direct_end = (tm_q == '0) || (v_q == '0);
  assign status_o.div_done   = div_done;

  assign diff_w = speed_q - stop_speed_q;
  assign up_w   = {1'b0, speed_q} + {1'b0, accel_q};
  assign r_w    = {1'b0, na_q} + {1'b0, quo_w[TICK_W-1:0]};

  assign div_go = (cmd_i == CMD_CDIV_GO) || (cmd_i == CMD_FDIV_GO);
  always_comb begin
    if (cmd_i == CMD_CDIV_GO) begin
      dividend_w = steps_q + STEPS_W'(sub_w) - STEPS_W'(1'b1);
      divisor_w  = DVS_W'(sub_w);
    end else begin
      dividend_w = steps_q[STEPS_W-1] ? '0 : steps_q;
      divisor_w  = {v_q, 1'b0};
    end
  end

  tmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (dividend_w),
    .divisor_i  (divisor_w),
    .quotient_o (quo_w),
    .done_o     (div_done)
  );

  always_comb begin
    drv_d = drv_q;   motor_d = motor_q; speed_d = speed_q; goal_d = goal_q;
    te_d  = te_q;    tl_d = tl_q;       dst_d = dst_q;     pos_d = pos_q;
    pgoal_d = pgoal_q; back_d = back_q; en_cnt_d = en_cnt_q; dis_cnt_d = dis_cnt_q;
    stat_d = stat_q; chg_d = chg_q;
    steps_d = steps_q; v_d = v_q; off_d = off_q; tm_d = tm_q;
    na_d = na_q; nd_d = nd_q; n_d = n_q;
    unique case (cmd_i)
      CMD_EXEC: begin
        stat_d = ST_ACCEPTED;
        chg_d  = 1'b0;
        unique case (kind_e'(kind_q))
          KIND_START: begin
            if (busy_w) begin
              stat_d = ST_BUSY;
            end else if (invalid_w) begin
              stat_d = ST_INVALID;
            end else begin
              chg_d     = 1'b1;
              back_d    = back_w;
              te_d      = '0;
              tl_d      = lim_q;
              goal_d    = req_q;
              pgoal_d   = tgt_q;
              speed_d   = start_speed_q;
              dis_cnt_d = dis_dly_q;
              steps_d   = STEPS_W'({dist_w, 9'b0});
              v_d       = {1'b0, start_speed_q};
              off_d     = '0;
              tm_d      = lim_q;
              na_d      = '0;
              nd_d      = '0;
              if (drv_q == DRV_OFF) begin
                en_cnt_d = en_dly_q;
                drv_d    = DRV_ENABLING;
              end
              motor_d = MOTOR_STARTING;
            end
          end
          KIND_TICK: begin
            unique case (drv_q)
              DRV_ENABLING: begin
                if (en_cnt_q == '0) drv_d = DRV_ON;
                else en_cnt_d = en_cnt_q - DLY_W'(1);
              end
              DRV_ON: begin
                if (motor_q == MOTOR_STOPPED) begin
                  if (dis_cnt_q != '0) dis_cnt_d = dis_cnt_q - DLY_W'(1);
                  else drv_d = DRV_OFF;
                end else begin
                  motor_d = MOTOR_MOVING;
                  if (te_q > dst_q) begin
                    if (speed_q > stop_speed_q) begin
                      speed_d = (decel_q > diff_w) ? stop_speed_q : speed_q - decel_q;
                      chg_d   = 1'b1;
                    end
                  end else if (speed_q < goal_q) begin
                    speed_d = (up_w > {1'b0, goal_q}) ? goal_q : up_w[SPEED_BITS-1:0];
                    chg_d   = 1'b1;
                  end
                  if (te_q >= tl_q) motor_d = MOTOR_STOPPED;
                  else te_d = te_q + TICK_W'(1);
                end
              end
              default: ;
            endcase
          end
          KIND_PULSE: begin
            if (pos_q != pgoal_q)
              pos_d = back_q ? pos_q - POSITION_BITS'(1) : pos_q + POSITION_BITS'(1);
            else
              motor_d = MOTOR_STOPPED;
          end
          KIND_STOP:    motor_d = MOTOR_STOPPED;
          KIND_DISABLE: drv_d = DRV_OFF;
          default: ;
        endcase
      end
      CMD_STEP: begin
        if (grow_zero_w) begin
          // zero speed with zero growth: the rest of the time goes at once
          na_d = na_q + tm_q;
          tm_d = '0;
        end else begin
          steps_d = steps_q - STEPS_W'(sub_w);
          if (dec_w) begin
            off_d = off_q + OFF_W'(grow_w);
            nd_d  = nd_q + TICK_W'(1);
          end else begin
            v_d  = v_q + V_W'(grow_w);
            na_d = na_q + TICK_W'(1);
          end
          tm_d = tm_q - TICK_W'(1);
        end
      end
      CMD_CDIV_TAKE: begin
        if (|quo_w[STEPS_W-1:TICK_W]) n_d = tm_q;
        else n_d = (quo_w[TICK_W-1:0] < tm_q) ? quo_w[TICK_W-1:0] : tm_q;
      end
      CMD_APPLY: begin
        steps_d = steps_q - prod_q[STEPS_W-1:0];
        if (dec_w) nd_d = nd_q + n_q;
        else na_d = na_q + n_q;
        tm_d = tm_q - n_q;
      end
      CMD_FDIV_TAKE: begin
        if ((|quo_w[STEPS_W-1:TICK_W]) || r_w[TICK_W]) dst_d = TICK_MAX;
        else dst_d = r_w[TICK_W-1:0];
      end
      CMD_FINAL: dst_d = (tm_q == '0) ? tl_q - nd_q : TICK_MAX;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_speed_q <= SPEED_BITS'(256);
      stop_speed_q  <= SPEED_BITS'(256);
      accel_q       <= SPEED_BITS'(16);
      decel_q       <= SPEED_BITS'(16);
      en_dly_q      <= DLY_W'(10);
      dis_dly_q     <= DLY_W'(100);
      drv_q         <= DRV_OFF;
      motor_q       <= MOTOR_STOPPED;
      speed_q       <= '0;
      goal_q        <= '0;
      te_q          <= '0;
      tl_q          <= '0;
      dst_q         <= '0;
      pos_q         <= '0;
      pgoal_q       <= '0;
      back_q        <= 1'b0;
      en_cnt_q      <= '0;
      dis_cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_addr_i))
          CFG_START_SPEED:   start_speed_q <= cfg_wdata_i;
          CFG_STOP_SPEED:    stop_speed_q  <= cfg_wdata_i;
          CFG_ACCEL_STEP:    accel_q       <= cfg_wdata_i;
          CFG_DECEL_STEP:    decel_q       <= cfg_wdata_i;
          CFG_ENABLE_DELAY:  en_dly_q      <= cfg_wdata_i[DLY_W-1:0];
          CFG_DISABLE_DELAY: dis_dly_q     <= cfg_wdata_i[DLY_W-1:0];
          default: ;
        endcase
      end
      drv_q     <= drv_d;
      motor_q   <= motor_d;
      speed_q   <= speed_d;
      goal_q    <= goal_d;
      te_q      <= te_d;
      tl_q      <= tl_d;
      dst_q     <= dst_d;
      pos_q     <= pos_d;
      pgoal_q   <= pgoal_d;
      back_q    <= back_d;
      en_cnt_q  <= en_cnt_d;
      dis_cnt_q <= dis_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LOAD) begin
      kind_q <= kind_i;
      tgt_q  <= target_position_i;
      req_q  <= speed_request_i;
      lim_q  <= move_limit_i;
    end
    stat_q  <= stat_d;
    chg_q   <= chg_d;
    steps_q <= steps_d;
    v_q     <= v_d;
    off_q   <= off_d;
    tm_q    <= tm_d;
    na_q    <= na_d;
    nd_q    <= nd_d;
    n_q     <= n_d;
    if (cmd_i == CMD_MUL) prod_q <= n_q * sub_w;
    if (cmd_i == CMD_OUT) begin
      o_stat_q    <= stat_q;
      o_drv_on_q  <= drv_q == DRV_ON;
      o_move_on_q <= motor_q == MOTOR_MOVING;
      o_speed_q   <= speed_q;
      o_chg_q     <= chg_q;
      o_pos_q     <= pos_q;
      o_motor_q   <= motor_q;
      o_drv_q     <= drv_q;
    end
  end

  assign status_code_o   = o_stat_q;
  assign driver_on_o     = o_drv_on_q;
  assign move_on_o       = o_move_on_q;
  assign speed_out_o     = o_speed_q;
  assign speed_changed_o = o_chg_q;
  assign position_now_o  = o_pos_q;
  assign motor_phase_o   = o_motor_q;
  assign driver_phase_o  = o_drv_q;

endmodule

[rtl/tmp_ctrl.sv]
`timescale 1ns / 1ps
module tmp_ctrl import tmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output cmd_e       cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_EXEC;
      S_EXEC:   state_d = (status_i.is_start && status_i.start_ok) ? S_PLAN : S_RESULT;
      S_PLAN: begin
        if (status_i.loop_go) state_d = status_i.need_div ? S_CDIV : S_PLAN;
        else state_d = status_i.direct_end ? S_RESULT : S_FDIV;
      end
      S_CDIV:   if (status_i.div_done) state_d = S_MUL;
      S_MUL:    state_d = S_APPLY;
      S_APPLY:  state_d = S_PLAN;
      S_FDIV:   if (status_i.div_done) state_d = S_RESULT;
      S_RESULT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = CMD_NONE;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) cmd_o = CMD_LOAD;
      S_EXEC:   cmd_o = CMD_EXEC;
      S_PLAN: begin
        if (status_i.loop_go) cmd_o = status_i.need_div ? CMD_CDIV_GO : CMD_STEP;
        else cmd_o = status_i.direct_end ? CMD_FINAL : CMD_FDIV_GO;
      end
      S_CDIV:   if (status_i.div_done) cmd_o = CMD_CDIV_TAKE;
      S_MUL:    cmd_o = CMD_MUL;
      S_APPLY:  cmd_o = CMD_APPLY;
      S_FDIV:   if (status_i.div_done) cmd_o = CMD_FDIV_TAKE;
      S_RESULT: if (out_free) cmd_o = CMD_OUT;
      default:  cmd_o = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_RESULT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/trapezoid_motion_profiler.sv]
`timescale 1ns / 1ps
// channel | dir | handshake               | beat
// in      | in  | in_valid_i / in_stall_o  | kind, target_position, speed_request, move_limit
// out     | out | out_valid_o / out_stall_i| status_code .. driver_phase
// cfg     | in  | cfg_we_i                 | cfg_addr_i, cfg_wdata_i
// One beat in, one beat out. Tick, pulse, stop, disable and refused starts pass only the
// execute and result states. An accepted start adds a plan step per ramp step of the plan,
// a divide, multiply and apply per constant-speed span (the divide on the shared 42-step
// serial divider), and a close, with the final divide when the close needs it.
// Reset: stopped, driver off, registers at defaults; no clearing pass.
// A new beat is taken while the previous result still waits in the output register.
module trapezoid_motion_profiler import tmp_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [CFG_IDX_W-1:0]            cfg_addr_i,
  input  logic [CFG_W-1:0]                cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [KIND_W-1:0]               kind_i,
  input  logic signed [POSITION_BITS-1:0] target_position_i,
  input  logic [SPEED_BITS-1:0]           speed_request_i,
  input  logic [TICK_W-1:0]               move_limit_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_code_o,
  output logic                            driver_on_o,
  output logic                            move_on_o,
  output logic [SPEED_BITS-1:0]           speed_out_o,
  output logic                            speed_changed_o,
  output logic signed [POSITION_BITS-1:0] position_now_o,
  output logic [1:0]                      motor_phase_o,
  output logic [1:0]                      driver_phase_o
);

  cmd_e       cmd;
  dp_status_t dp_status;

  tmp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  tmp_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (dp_status),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .kind_i            (kind_i),
    .target_position_i (target_position_i),
    .speed_request_i   (speed_request_i),
    .move_limit_i      (move_limit_i),
    .status_code_o     (status_code_o),
    .driver_on_o       (driver_on_o),
    .move_on_o         (move_on_o),
    .speed_out_o       (speed_out_o),
    .speed_changed_o   (speed_changed_o),
    .position_now_o    (position_now_o),
    .motor_phase_o     (motor_phase_o),
    .driver_phase_o    (driver_phase_o)
  );

endmodule

[rtl/tmp_checker.sv]
`timescale 1ns / 1ps
`include "trapezoid_motion_profiler_defines.svh"
module tmp_checker import tmp_pkg::*; (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [1:0]                      status_code_o,
  input logic                            driver_on_o,
  input logic                            move_on_o,
  input logic                            speed_changed_o,
  input logic signed [POSITION_BITS-1:0] position_now_o,
  input logic [1:0]                      motor_phase_o,
  input logic [1:0]                      driver_phase_o
);

  `TMP_ASSERT(a_status_legal, clk_i, rst_ni, out_valid_o |-> (status_code_o == ST_ACCEPTED || status_code_o == ST_BUSY || status_code_o == ST_INVALID), "illegal status code")
  `TMP_ASSERT(a_driver_level, clk_i, rst_ni, out_valid_o |-> (driver_on_o == (driver_phase_o == DRV_ON)), "driver_on disagrees with phase")
  `TMP_ASSERT(a_move_level, clk_i, rst_ni, out_valid_o |-> (move_on_o == (motor_phase_o == MOTOR_MOVING)), "move_on disagrees with phase")
  `TMP_ASSERT(a_refused_quiet, clk_i, rst_ni, (out_valid_o && status_code_o != ST_ACCEPTED) |-> !speed_changed_o, "refused start changed speed")
  `TMP_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, position_now_o, "stalled result moved")

endmodule

bind trapezoid_motion_profiler tmp_checker u_chk (.*);

[tb/trapezoid_motion_profiler_test.sv]
`timescale 1ns / 1ps
module trapezoid_motion_profiler_test;
  import tmp_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 370;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic [POSITION_BITS-1:0] target;
    logic [SPEED_BITS-1:0]    speed_req;
    logic [TICK_W-1:0]        limit;
  } move_cmd_t;

  typedef struct {
    logic [1:0]               status;
    logic                     driver_on;
    logic                     move_on;
    logic [SPEED_BITS-1:0]    speed;
    logic                     changed;
    logic [POSITION_BITS-1:0] position;
    logic [1:0]               motor;
    logic [1:0]               driver;
  } motion_state_t;

  typedef struct {
    move_cmd_t cmd;
    bit        check_status;
    status_e   status;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [KIND_W-1:0] kind_i = '0;
  logic signed [POSITION_BITS-1:0] target_position_i = '0;
  logic [SPEED_BITS-1:0] speed_request_i = '0;
  logic [TICK_W-1:0] move_limit_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] status_code_o;
  logic driver_on_o;
  logic move_on_o;
  logic [SPEED_BITS-1:0] speed_out_o;
  logic speed_changed_o;
  logic signed [POSITION_BITS-1:0] position_now_o;
  logic [1:0] motor_phase_o;
  logic [1:0] driver_phase_o;

  trapezoid_motion_profiler u_dut (.*);

  always #5 clk_i = ~clk_i;

  // profile registers as the block holds them
  logic [SPEED_BITS-1:0] r_start, r_stop, r_accel, r_decel;
  logic [DLY_W-1:0] r_en_dly, r_dis_dly;
  // motion state
  drv_e m_drv;
  motor_e m_mot;
  logic [SPEED_BITS-1:0] m_speed, m_goal;
  logic [TICK_W-1:0] m_elapsed, m_limit, m_decel_at;
  logic [POSITION_BITS-1:0] m_pos, m_goal_pos;
  bit m_back;
  logic [DLY_W-1:0] m_en_cnt, m_dis_cnt;

  motion_state_t motion_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;
  bit hold_go = 0;
  bit hold_done = 0;

  function automatic logic [TICK_W-1:0] decel_tick(longint span, longint req, longint limit);
    longint steps, v, off, tm, na, nd, d, sub, grow, n, c, r;
    bit dec;
    steps = span << 9;
    v = r_start; off = 0; tm = limit; na = 0; nd = 0;
    while (v < req && steps > 0 && tm != 0) begin
      d = v - off;
      dec = d > longint'(r_stop);
      sub = dec ? d : v;
      grow = dec ? r_decel : r_accel;
      if (grow == 0) begin
        // constant speed span: taken at once, up to the remaining steps or time
        n = tm;
        if (sub != 0) begin
          c = (steps + sub - 1) / sub;
          if (c < n) n = c;
        end
        steps -= n * sub;
        if (dec) nd += n; else na += n;
        tm -= n;
      end else begin
        steps -= sub;
        if (dec) begin off += grow; nd++; end
        else begin v += grow; na++; end
        tm--;
      end
    end
    if (steps < 0) steps = 0;
    if (tm == 0) return TICK_W'(limit - nd);
    if (v == 0) return TICK_MAX;
    r = na + steps / (2 * v);
    return (r > longint'(TICK_MAX)) ? TICK_MAX : TICK_W'(r);
  endfunction

  function automatic logic [1:0] start_move(move_cmd_t cmd);
    longint tgt, pos;
    if (m_mot != MOTOR_STOPPED) return ST_BUSY;
    if (cmd.limit == 0 || cmd.speed_req == 0) return ST_INVALID;
    tgt = longint'($signed(cmd.target));
    pos = longint'($signed(m_pos));
    if (tgt == pos) return ST_INVALID;
    m_back = tgt < pos;
    m_elapsed = '0;
    m_limit = cmd.limit;
    m_goal = cmd.speed_req;
    m_goal_pos = cmd.target;
    m_speed = r_start;
    m_dis_cnt = r_dis_dly;
    m_decel_at = decel_tick(m_back ? pos - tgt : tgt - pos, cmd.speed_req, cmd.limit);
    if (m_drv == DRV_OFF) begin
      m_en_cnt = r_en_dly;
      m_drv = DRV_ENABLING;
    end
    m_mot = MOTOR_STARTING;
    return ST_ACCEPTED;
  endfunction

  function automatic bit run_tick();
    longint s;
    bit changed;
    changed = 0;
    if (m_drv == DRV_ENABLING) begin
      if (m_en_cnt == 0) m_drv = DRV_ON;
      else m_en_cnt--;
      return 0;
    end
    if (m_drv != DRV_ON) return 0;
    if (m_mot == MOTOR_STOPPED) begin
      if (m_dis_cnt != 0) m_dis_cnt--;
      else m_drv = DRV_OFF;
      return 0;
    end
    if (m_mot == MOTOR_STARTING) m_mot = MOTOR_MOVING;
    if (m_elapsed > m_decel_at) begin
      if (m_speed > r_stop) begin
        if (r_decel > m_speed - r_stop) m_speed = r_stop;
        else m_speed -= r_decel;
        changed = 1;
      end
    end else if (m_speed < m_goal) begin
      s = longint'(m_speed) + r_accel;
      m_speed = (s > longint'(m_goal)) ? m_goal : SPEED_BITS'(s);
      changed = 1;
    end
    if (m_elapsed >= m_limit) m_mot = MOTOR_STOPPED;
    else m_elapsed++;
    return changed;
  endfunction

  function automatic motion_state_t next_motion(move_cmd_t cmd);
    motion_state_t o;
    o.status = ST_ACCEPTED;
    o.changed = 0;
    case (cmd.kind)
      KIND_START: begin
        o.status = start_move(cmd);
        o.changed = (o.status == ST_ACCEPTED);
      end
      KIND_TICK: o.changed = run_tick();
      KIND_PULSE: begin
        if (m_pos != m_goal_pos) m_pos = m_back ? m_pos - 1 : m_pos + 1;
        else m_mot = MOTOR_STOPPED;
      end
      KIND_STOP: m_mot = MOTOR_STOPPED;
      KIND_DISABLE: m_drv = DRV_OFF;
      default: ;
    endcase
    o.driver_on = (m_drv == DRV_ON);
    o.move_on = (m_mot == MOTOR_MOVING);
    o.speed = m_speed;
    o.position = m_pos;
    o.motor = m_mot;
    o.driver = m_drv;
    return o;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_START_SPEED: r_start = val;
      CFG_STOP_SPEED: r_stop = val;
      CFG_ACCEL_STEP: r_accel = val;
      CFG_DECEL_STEP: r_decel = val;
      CFG_ENABLE_DELAY: r_en_dly = val[DLY_W-1:0];
      CFG_DISABLE_DELAY: r_dis_dly = val[DLY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_profile(int phase);
    logic [CFG_W-1:0] v[6];
    case (phase)
      0: v = '{24'd256, 24'd256, 24'd16, 24'd16, 24'd10, 24'd100};
      2: v = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0};
      3: v = '{TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, 24'hFFFFFF, 24'hFFFFFF};
      default: v = '{CFG_W'($urandom_range(0, 4096)), CFG_W'($urandom_range(0, 2048)),
                     CFG_W'($urandom_range(0, 512)), CFG_W'($urandom_range(0, 512)),
                     CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 60))};
    endcase
    for (int i = 0; i < 6; i++) write_reg(cfg_idx_e'(i), v[i]);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_cmd(move_cmd_t cmd, bit check_status, status_e st);
    motion_state_t o;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= cmd.kind;
    target_position_i <= cmd.target;
    speed_request_i <= cmd.speed_req;
    move_limit_i <= cmd.limit;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    o = next_motion(cmd);
    motion_q.push_back(o);
    if (check_status && o.status != st) begin
      $error("status_code table: expected %0d actual %0d", st, o.status);
      errors++;
    end
  endtask

  function automatic move_cmd_t random_cmd();
    move_cmd_t c;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 12) c.kind = KIND_START;
    else if (sel < 60) c.kind = KIND_TICK;
    else if (sel < 88) c.kind = KIND_PULSE;
    else if (sel < 93) c.kind = KIND_STOP;
    else if (sel < 97) c.kind = KIND_DISABLE;
    else c.kind = KIND_W'($urandom_range(5, 7));
    sel = $urandom_range(0, 9);
    if (sel < 7) c.target = m_pos + POSITION_BITS'($urandom_range(0, 60)) - 30;
    else c.target = POSITION_BITS'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 5) c.speed_req = SPEED_BITS'($urandom_range(1, 4096));
    else if (sel < 8) c.speed_req = SPEED_BITS'($urandom);
    else if (sel < 9) c.speed_req = TICK_MAX;
    else c.speed_req = '0;
    sel = $urandom_range(0, 99);
    if (sel < 75) c.limit = TICK_W'($urandom_range(1, 64));
    else if (sel < 92) c.limit = TICK_W'($urandom_range(65, 1000));
    else if (sel < 97) c.limit = '0;
    else begin
      // long limit only with a short ramp, keeps planning cheap
      c.limit = TICK_W'($urandom);
      c.speed_req = SPEED_BITS'($urandom_range(1, 2048));
    end
    return c;
  endfunction

  script_row_t script[$] = '{
    '{'{KIND_START, 32'd0, 24'd100, 24'd10}, 1, ST_INVALID},
    '{'{KIND_START, 32'd50, 24'd0, 24'd10}, 1, ST_INVALID},
    '{'{KIND_START, 32'd50, 24'd100, 24'd0}, 1, ST_INVALID},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 1, ST_ACCEPTED},
    '{'{KIND_START, 32'd20, 24'd1024, 24'd30}, 1, ST_ACCEPTED},
    '{'{KIND_START, 32'd20, 24'd1024, 24'd30}, 1, ST_BUSY},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_TICK, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_PULSE, 32'd0, 24'd0, 24'd0}, 1, ST_ACCEPTED},
    '{'{KIND_PULSE, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_STOP, 32'd0, 24'd0, 24'd0}, 1, ST_ACCEPTED},
    '{'{KIND_START, 32'h80000000, 24'hFFFFFF, 24'd40}, 1, ST_ACCEPTED},
    '{'{KIND_PULSE, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_UNUSED, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1, ST_ACCEPTED},
    '{'{KIND_DISABLE, 32'd0, 24'd0, 24'd0}, 1, ST_ACCEPTED},
    '{'{KIND_STOP, 32'd0, 24'd0, 24'd0}, 0, ST_ACCEPTED},
    '{'{KIND_START, 32'h7FFFFFFF, 24'd1, 24'd1}, 1, ST_ACCEPTED}
  };

  initial begin
    r_start = 24'd256; r_stop = 24'd256; r_accel = 24'd16; r_decel = 24'd16;
    r_en_dly = 16'd10; r_dis_dly = 16'd100;
    m_drv = DRV_OFF; m_mot = MOTOR_STOPPED;
    m_speed = '0; m_goal = '0; m_elapsed = '0; m_limit = '0; m_decel_at = '0;
    m_pos = '0; m_goal_pos = '0; m_back = 0; m_en_cnt = '0; m_dis_cnt = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) wait_drained();
      set_profile(p);
      if (p == 0)
        foreach (script[i]) send_cmd(script[i].cmd, script[i].check_status, script[i].status);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == 100) hold_go = 1;
        if (p == PHASES - 1 && n == ITEMS_PER_PHASE - 150) quiet = 1;
        send_cmd(random_cmd(), 0, ST_ACCEPTED);
      end
    end
    wait_drained();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // result side back-pressure, plus one long hold to fill the block
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_done = 1;
        @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        @(posedge clk_i);
      end
    end
  end

  // outputs are stable between edges; a beat seen here is taken at the next edge
  always @(negedge clk_i) begin
    motion_state_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (motion_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = motion_q.pop_front();
        if (status_code_o !== e.status) begin
          $error("status_code: expected %0d actual %0d", e.status, status_code_o); errors++;
        end
        if (driver_on_o !== e.driver_on) begin
          $error("driver_on: expected %0d actual %0d", e.driver_on, driver_on_o); errors++;
        end
        if (move_on_o !== e.move_on) begin
          $error("move_on: expected %0d actual %0d", e.move_on, move_on_o); errors++;
        end
        if (speed_out_o !== e.speed) begin
          $error("speed_out: expected %0d actual %0d", e.speed, speed_out_o); errors++;
        end
        if (speed_changed_o !== e.changed) begin
          $error("speed_changed: expected %0d actual %0d", e.changed, speed_changed_o);
          errors++;
        end
        if (position_now_o !== e.position) begin
          $error("position_now: expected %0d actual %0d", $signed(e.position),
                 position_now_o);
          errors++;
        end
        if (motor_phase_o !== e.motor) begin
          $error("motor_phase: expected %0d actual %0d", e.motor, motor_phase_o); errors++;
        end
        if (driver_phase_o !== e.driver) begin
          $error("driver_phase: expected %0d actual %0d", e.driver, driver_phase_o); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/tmp_pkg.sv
rtl/tmp_div.sv
rtl/tmp_datapath.sv
rtl/tmp_ctrl.sv
rtl/trapezoid_motion_profiler.sv
rtl/tmp_checker.sv
tb/trapezoid_motion_profiler_test.sv
